FILE: sv/lbdh_pkg.sv
// Shared types and constants of the log-binned distance histogram.
package lbdh_pkg;

  localparam int unsigned DIST_W   = 32;
  localparam int unsigned RATIO_W  = 16;
  localparam int unsigned BCNT_W   = 7;
  localparam int unsigned BIN_W    = 6;
  localparam int unsigned ORIENT_W = 2;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned OUT_CNT_W = 32;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned ROUND_UP = (1 << FRAC_W) - 1;

  localparam logic [DIST_W-1:0]  MIN_DIST_RST = 32'd1000;
  localparam logic [DIST_W-1:0]  MAX_DIST_RST = 32'd1000000;
  localparam logic [RATIO_W-1:0] RATIO_RST    = 16'd282;
  localparam logic [BCNT_W-1:0]  BCNT_RST     = 7'd64;

  typedef enum logic [1:0] {
    CFG_MIN_DIST  = 2'd0,
    CFG_MAX_DIST  = 2'd1,
    CFG_RATIO     = 2'd2,
    CFG_BIN_COUNT = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_READ   = 1'b1
  } cmd_e;

  typedef enum logic [ORIENT_W-1:0] {
    ORIENT_IN    = 2'd0,
    ORIENT_OUT   = 2'd1,
    ORIENT_SAME  = 2'd2,
    ORIENT_OTHER = 2'd3
  } orient_e;

  typedef struct packed {
    logic start;
    logic rd_mode;
  } walk_ctl_t;

endpackage

FILE: sv/lbdh_walk.sv
// Boundary walk: one shared Q8.8 multiply step per cycle, stepping the bin index.
module lbdh_walk #(
  parameter int unsigned ADDR_W = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lbdh_pkg::walk_ctl_t          ctl_i,
  input  logic [lbdh_pkg::DIST_W-1:0]  min_i,
  input  logic [lbdh_pkg::DIST_W-1:0]  dist_i,
  input  logic [lbdh_pkg::RATIO_W-1:0] ratio_i,
  input  logic [ADDR_W-1:0]            last_i,
  output logic [lbdh_pkg::DIST_W-1:0]  bound_o,
  output logic [ADDR_W-1:0]            bin_o,
  output logic                         done_o
);
  import lbdh_pkg::*;

  localparam int unsigned PROD_W = DIST_W + RATIO_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned SCL_W  = SUM_W - FRAC_W;

  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  sum;
  logic [SCL_W-1:0]  scaled;
  logic [DIST_W-1:0] next_b;
  logic              stop;
  logic              run_q, run_d;
  logic              done_q, done_d;
  logic              mode_q;
  logic [DIST_W-1:0] bound_q, bound_d;
  logic [ADDR_W-1:0] bin_q, bin_d;

  assign prod   = PROD_W'(bound_q) * PROD_W'(ratio_i);
  assign sum    = SUM_W'(prod) + SUM_W'(ROUND_UP);
  assign scaled = sum[SUM_W-1:FRAC_W];
  assign next_b = (|scaled[SCL_W-1:DIST_W]) ? '1 : scaled[DIST_W-1:0];
  assign stop   = (bin_q == last_i) || (!mode_q && (next_b > dist_i));

  always_comb begin
    run_d   = run_q;
    done_d  = 1'b0;
    bound_d = bound_q;
    bin_d   = bin_q;
    if (ctl_i.start) begin
      run_d   = 1'b1;
      bound_d = min_i;
      bin_d   = '0;
    end else if (run_q) begin
      if (stop) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        bound_d = next_b;
        bin_d   = bin_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bound_q <= bound_d;
    bin_q   <= bin_d;
    if (ctl_i.start) begin
      mode_q <= ctl_i.rd_mode;
    end
  end

  assign bound_o = bound_q;
  assign bin_o   = bin_q;
  assign done_o  = done_q;

endmodule

FILE: sv/lbdh_store.sv
// Counter store: one row of three counters per bin, cleared by a sweep after reset.
module lbdh_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned ROW_W = 96
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [ROW_W-1:0]         wr_data_i,
  output logic [ROW_W-1:0]         rd_data_o,
  output logic                     clr_busy_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [ROW_W-1:0] mem_q [DEPTH];
  logic [ROW_W-1:0] rd_data_q;
  logic             clr_q, clr_d;
  logic [AW-1:0]    clr_addr_q, clr_addr_d;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_q;

endmodule

FILE: sv/log_binned_distance_histogram.sv
// Top level of the log-binned distance histogram.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command per transfer:
//   record a read pair (same_chrom_i, distance_i, orientation_i) or read back
//   bin read_bin_i. Output channel (out_valid_o / out_stall_i) returns one
//   result per command: bin, accepted flag, bin lower bound and three counts.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at
//   once. Make them only while the block is idle; the block does not check.
// Timing:
//   A command holds the block while the boundary walk steps to its bin k,
//   one multiply step per cycle on a single shared multiplier, and then
//   through the store read, the counter update and the result register.
//   Rejected pairs and reads beyond the store skip the walk. in_stall_o
//   stays high while a command is in flight.
// Reset:
//   Registers return to their defaults and the counter store is swept to zero,
//   one bin per cycle over all MAX_BINS bins; in_stall_o is high meanwhile.
// Back-pressure:
//   A result waits in the output register while out_stall_i is high; the next
//   command may be taken and worked on, and is held back only at its end.
module log_binned_distance_histogram #(
  parameter int unsigned MAX_BINS    = 64,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  lbdh_pkg::cfg_idx_e            cfg_idx_i,
  input  logic [lbdh_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic                          same_chrom_i,
  input  logic [lbdh_pkg::DIST_W-1:0]   distance_i,
  input  logic [lbdh_pkg::ORIENT_W-1:0] orientation_i,
  input  logic [lbdh_pkg::BIN_W-1:0]    read_bin_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lbdh_pkg::BIN_W-1:0]    bin_o,
  output logic                          accepted_o,
  output logic [lbdh_pkg::DIST_W-1:0]   bin_lower_o,
  output logic [lbdh_pkg::OUT_CNT_W-1:0] count_in_o,
  output logic [lbdh_pkg::OUT_CNT_W-1:0] count_out_o,
  output logic [lbdh_pkg::OUT_CNT_W-1:0] count_same_o
);
  import lbdh_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_BINS);
  localparam int unsigned CW    = COUNT_WIDTH;
  localparam int unsigned ROW_W = 3 * CW;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_UPD,
    S_DONE
  } state_e;

  state_e            state_q;
  logic [DIST_W-1:0] min_q, max_q;
  logic [RATIO_W-1:0] ratio_q;
  logic [BCNT_W-1:0] bcnt_q;

  logic              cmd_q;
  logic [ORIENT_W-1:0] orient_q;
  logic [DIST_W-1:0] dist_q;
  logic [AW-1:0]     last_q;

  logic [BIN_W-1:0]  res_bin_q;
  logic              res_acc_q;
  logic [DIST_W-1:0] res_lower_q;
  logic [OUT_CNT_W-1:0] res_in_q, res_out_q, res_same_q;

  logic              out_valid_q;
  logic [BIN_W-1:0]  out_bin_q;
  logic              out_acc_q;
  logic [DIST_W-1:0] out_lower_q;
  logic [OUT_CNT_W-1:0] out_in_q, out_out_q, out_same_q;

  logic              in_xfer;
  logic              rb_ok;
  logic              pair_ok;
  logic              need_walk;
  logic [DIST_W-1:0] dclamp;
  logic [AW-1:0]     lim;
  walk_ctl_t         walk_ctl;
  logic [DIST_W-1:0] walk_bound;
  logic [AW-1:0]     walk_bin;
  logic              walk_done;
  logic              mem_rd;
  logic              mem_wr;
  logic              counted;
  logic [ROW_W-1:0]  rd_row;
  logic [ROW_W-1:0]  new_row;
  logic              clr_busy;
  logic [CW-1:0]     cnt;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign rb_ok      = 32'(read_bin_i) < 32'(MAX_BINS);
  assign pair_ok    = same_chrom_i && (distance_i >= min_q);
  assign need_walk  = (cmd_i == CMD_READ) ? rb_ok : pair_ok;
  assign dclamp     = (distance_i > max_q) ? max_q : distance_i;

  always_comb begin
    if (bcnt_q == '0) begin
      lim = '0;
    end else if (32'(bcnt_q) > 32'(MAX_BINS)) begin
      lim = AW'(MAX_BINS - 1);
    end else begin
      lim = AW'(bcnt_q - BCNT_W'(1));
    end
  end

  assign walk_ctl.start   = in_xfer && need_walk;
  assign walk_ctl.rd_mode = (cmd_i == CMD_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= MIN_DIST_RST;
      max_q   <= MAX_DIST_RST;
      ratio_q <= RATIO_RST;
      bcnt_q  <= BCNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_DIST:  min_q   <= cfg_wdata_i[DIST_W-1:0];
        CFG_MAX_DIST:  max_q   <= cfg_wdata_i[DIST_W-1:0];
        CFG_RATIO:     ratio_q <= cfg_wdata_i[RATIO_W-1:0];
        CFG_BIN_COUNT: bcnt_q  <= cfg_wdata_i[BCNT_W-1:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q    <= cmd_i;
      orient_q <= orientation_i;
      dist_q   <= dclamp;
      last_q   <= (cmd_i == CMD_READ) ? AW'(read_bin_i) : lim;
    end
  end

  lbdh_walk #(
    .ADDR_W (AW)
  ) u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (walk_ctl),
    .min_i   (min_q),
    .dist_i  (dist_q),
    .ratio_i (ratio_q),
    .last_i  (last_q),
    .bound_o (walk_bound),
    .bin_o   (walk_bin),
    .done_o  (walk_done)
  );

  assign counted = (cmd_q == CMD_RECORD) && (orient_q != ORIENT_OTHER);
  assign mem_rd  = (state_q == S_WALK) && walk_done;
  assign mem_wr  = (state_q == S_UPD) && counted;

  always_comb begin
    new_row = rd_row;
    cnt     = '0;
    for (int l = 0; l < 3; l++) begin
      cnt = rd_row[l*CW +: CW];
      if (counted && (orient_q == ORIENT_W'(l)) && (cnt != '1)) begin
        new_row[l*CW +: CW] = cnt + CW'(1);
      end
    end
  end

  lbdh_store #(
    .DEPTH (MAX_BINS),
    .ROW_W (ROW_W)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (mem_rd),
    .wr_en_i    (mem_wr),
    .addr_i     (walk_bin),
    .wr_data_i  (new_row),
    .rd_data_o  (rd_row),
    .clr_busy_o (clr_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
      res_bin_q   <= '0;
      res_acc_q   <= 1'b0;
      res_lower_q <= '0;
      res_in_q    <= '0;
      res_out_q   <= '0;
      res_same_q  <= '0;
      out_bin_q   <= '0;
      out_acc_q   <= 1'b0;
      out_lower_q <= '0;
      out_in_q    <= '0;
      out_out_q   <= '0;
      out_same_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (!clr_busy) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            res_bin_q   <= (cmd_i == CMD_READ) ? read_bin_i : '0;
            res_acc_q   <= 1'b0;
            res_lower_q <= '0;
            res_in_q    <= '0;
            res_out_q   <= '0;
            res_same_q  <= '0;
            state_q     <= need_walk ? S_WALK : S_DONE;
          end
        end
        S_WALK: begin
          if (walk_done) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          res_bin_q   <= BIN_W'(walk_bin);
          res_acc_q   <= counted;
          res_lower_q <= walk_bound;
          res_in_q    <= OUT_CNT_W'(new_row[0*CW +: CW]);
          res_out_q   <= OUT_CNT_W'(new_row[1*CW +: CW]);
          res_same_q  <= OUT_CNT_W'(new_row[2*CW +: CW]);
          state_q     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_bin_q   <= res_bin_q;
            out_acc_q   <= res_acc_q;
            out_lower_q <= res_lower_q;
            out_in_q    <= res_in_q;
            out_out_q   <= res_out_q;
            out_same_q  <= res_same_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign bin_o        = out_bin_q;
  assign accepted_o   = out_acc_q;
  assign bin_lower_o  = out_lower_q;
  assign count_in_o   = out_in_q;
  assign count_out_o  = out_out_q;
  assign count_same_o = out_same_q;

endmodule

FILE: sv/lbdh_chk.sv
// Port-level checker of the log-binned distance histogram and its bind.
module lbdh_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [lbdh_pkg::BIN_W-1:0]     bin_o,
  input logic                           accepted_o,
  input logic [lbdh_pkg::DIST_W-1:0]    bin_lower_o,
  input logic [lbdh_pkg::OUT_CNT_W-1:0] count_in_o,
  input logic [lbdh_pkg::OUT_CNT_W-1:0] count_out_o,
  input logic [lbdh_pkg::OUT_CNT_W-1:0] count_same_o
);

  logic in_xfer;

  assign in_xfer = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bin_o) && $stable(accepted_o)
      && $stable(bin_lower_o) && $stable(count_in_o) && $stable(count_out_o)
      && $stable(count_same_o))
    else $error("stalled result changed");

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("block took a second command while one was in flight");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !$rose(out_valid_o))
    else $error("result appeared in the cycle after the command");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while the block was idle");

endmodule

bind log_binned_distance_histogram lbdh_chk u_lbdh_chk (.*);

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the log-binned distance histogram: directed table then random phases.
module tb;
  import lbdh_pkg::*;

  localparam int NBINS = 64;
  localparam logic [OUT_CNT_W-1:0] CNT_SAT = '1;

  typedef struct packed {
    cmd_e              cmd;
    logic              same;
    logic [DIST_W-1:0] span;
    orient_e           orient;
    logic [BIN_W-1:0]  rbin;
  } pair_cmd_t;

  typedef struct packed {
    logic [BIN_W-1:0]     bin;
    logic                 acc;
    logic [DIST_W-1:0]    lower;
    logic [OUT_CNT_W-1:0] c_in;
    logic [OUT_CNT_W-1:0] c_out;
    logic [OUT_CNT_W-1:0] c_same;
  } bin_report_t;

  typedef struct packed {
    pair_cmd_t   req;
    logic        typed;
    bin_report_t rep;
  } dir_row_t;

  typedef struct packed {
    logic [DIST_W-1:0]  min_d;
    logic [DIST_W-1:0]  max_d;
    logic [RATIO_W-1:0] ratio;
    logic [BCNT_W-1:0]  nbins;
    logic               rnd;
    logic [6:0]         tx_pct;
    logic [6:0]         rx_pct;
    logic [10:0]        n_items;
  } phase_t;

  localparam bin_report_t ZERO_REP = '0;

  localparam dir_row_t DIR_ROWS [20] = '{
    '{'{CMD_READ,   1'b0, 32'd0,          ORIENT_IN,    6'd0},  1'b1,
      '{6'd0, 1'b0, 32'd1000, 32'd0, 32'd0, 32'd0}},
    '{'{CMD_READ,   1'b1, 32'hFFFF_FFFF,  ORIENT_OTHER, 6'd63}, 1'b0, ZERO_REP},
    '{'{CMD_RECORD, 1'b0, 32'd5000,       ORIENT_IN,    6'd0},  1'b1, ZERO_REP},
    '{'{CMD_RECORD, 1'b1, 32'd999,        ORIENT_IN,    6'd0},  1'b1, ZERO_REP},
    '{'{CMD_RECORD, 1'b1, 32'd0,          ORIENT_SAME,  6'd0},  1'b1, ZERO_REP},
    '{'{CMD_RECORD, 1'b1, 32'd1000,       ORIENT_IN,    6'd0},  1'b1,
      '{6'd0, 1'b1, 32'd1000, 32'd1, 32'd0, 32'd0}},
    '{'{CMD_RECORD, 1'b1, 32'd1000,       ORIENT_OUT,   6'd0},  1'b1,
      '{6'd0, 1'b1, 32'd1000, 32'd1, 32'd1, 32'd0}},
    '{'{CMD_RECORD, 1'b1, 32'd1000,       ORIENT_SAME,  6'd0},  1'b1,
      '{6'd0, 1'b1, 32'd1000, 32'd1, 32'd1, 32'd1}},
    '{'{CMD_RECORD, 1'b1, 32'd1000,       ORIENT_OTHER, 6'd0},  1'b1,
      '{6'd0, 1'b0, 32'd1000, 32'd1, 32'd1, 32'd1}},
    '{'{CMD_RECORD, 1'b1, 32'd1101,       ORIENT_IN,    6'd0},  1'b0, ZERO_REP},
    '{'{CMD_RECORD, 1'b1, 32'd1102,       ORIENT_IN,    6'd0},  1'b0, ZERO_REP},
    '{'{CMD_RECORD, 1'b1, 32'hFFFF_FFFF,  ORIENT_OUT,   6'd0},  1'b0, ZERO_REP},
    '{'{CMD_RECORD, 1'b1, 32'd1000000,    ORIENT_SAME,  6'd0},  1'b0, ZERO_REP},
    '{'{CMD_RECORD, 1'b1, 32'd1000001,    ORIENT_OTHER, 6'd0},  1'b0, ZERO_REP},
    '{'{CMD_READ,   1'b0, 32'd0,          ORIENT_IN,    6'd63}, 1'b0, ZERO_REP},
    '{'{CMD_READ,   1'b0, 32'd0,          ORIENT_SAME,  6'h2A}, 1'b0, ZERO_REP},
    '{'{CMD_READ,   1'b1, 32'h5555_5555,  ORIENT_OUT,   6'h15}, 1'b0, ZERO_REP},
    '{'{CMD_RECORD, 1'b0, 32'hFFFF_FFFF,  ORIENT_OTHER, 6'h3F}, 1'b1, ZERO_REP},
    '{'{CMD_RECORD, 1'b1, 32'h5555_5555,  ORIENT_IN,    6'h2A}, 1'b0, ZERO_REP},
    '{'{CMD_RECORD, 1'b1, 32'hAAAA_AAAA,  ORIENT_OUT,   6'h15}, 1'b0, ZERO_REP}
  };

  localparam phase_t PHASES [8] = '{
    '{MIN_DIST_RST,  MAX_DIST_RST,   RATIO_RST, BCNT_RST, 1'b0, 7'd0,  7'd0,  11'd200},
    '{32'd1,         32'hFFFF_FFFF,  16'd257,   7'd64,    1'b0, 7'd50, 7'd0,  11'd200},
    '{32'hFFFF_FFFF, 32'd1,          16'hFFFF,  7'd1,     1'b0, 7'd0,  7'd50, 11'd100},
    '{32'd100,       32'd100000,     16'd512,   7'd16,    1'b0, 7'd10, 7'd10, 11'd200},
    '{32'd5,         32'd70000,      16'd256,   7'd127,   1'b0, 7'd0,  7'd0,  11'd150},
    '{32'd2,         32'd3000,       16'd0,     7'd0,     1'b0, 7'd50, 7'd0,  11'd150},
    '{32'd0,         32'd0,          16'd0,     7'd0,     1'b1, 7'd0,  7'd50, 11'd150},
    '{32'd0,         32'd0,          16'd0,     7'd0,     1'b1, 7'd10, 7'd10, 11'd150}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  cfg_idx_e              cfg_idx_i = CFG_MIN_DIST;
  logic [CFG_W-1:0]      cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  cmd_i = 1'b0;
  logic                  same_chrom_i = 1'b0;
  logic [DIST_W-1:0]     distance_i = '0;
  logic [ORIENT_W-1:0]   orientation_i = '0;
  logic [BIN_W-1:0]      read_bin_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [BIN_W-1:0]      bin_o;
  logic                  accepted_o;
  logic [DIST_W-1:0]     bin_lower_o;
  logic [OUT_CNT_W-1:0]  count_in_o;
  logic [OUT_CNT_W-1:0]  count_out_o;
  logic [OUT_CNT_W-1:0]  count_same_o;

  logic [DIST_W-1:0]     hist_min;
  logic [DIST_W-1:0]     hist_max;
  logic [RATIO_W-1:0]    hist_ratio;
  logic [BCNT_W-1:0]     hist_nbins;
  logic [OUT_CNT_W-1:0]  tally_in [NBINS];
  logic [OUT_CNT_W-1:0]  tally_out [NBINS];
  logic [OUT_CNT_W-1:0]  tally_same [NBINS];

  bin_report_t           bin_reports_due [$];
  int unsigned           mismatches = 0;
  int unsigned           tx_pct = 0;
  int unsigned           rx_pct = 0;

  log_binned_distance_histogram uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [DIST_W-1:0] grow(input logic [DIST_W-1:0] b);
    logic [63:0] n;
    n = ({32'd0, b} * {48'd0, hist_ratio} + 64'(ROUND_UP)) >> FRAC_W;
    return (n > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : n[31:0];
  endfunction

  function automatic logic [DIST_W-1:0] lower_bound(input int k);
    logic [DIST_W-1:0] b;
    b = hist_min;
    for (int i = 0; i < k; i++) b = grow(b);
    return b;
  endfunction

  function automatic int bins_used();
    if (hist_nbins == 0) return 1;
    if (int'(hist_nbins) > NBINS) return NBINS;
    return int'(hist_nbins);
  endfunction

  function automatic bin_report_t report_of(input int k);
    bin_report_t r;
    r = '0;
    r.bin = BIN_W'(k);
    r.lower = lower_bound(k);
    r.c_in = tally_in[k];
    r.c_out = tally_out[k];
    r.c_same = tally_same[k];
    return r;
  endfunction

  function automatic bin_report_t bin_and_count(input pair_cmd_t c);
    bin_report_t r;
    logic [DIST_W-1:0] d;
    logic [DIST_W-1:0] b;
    int k;
    int n;
    r = '0;
    if (c.cmd == CMD_READ) return report_of(int'(c.rbin));
    if (!c.same || c.span < hist_min) return r;
    d = (c.span > hist_max) ? hist_max : c.span;
    n = bins_used();
    k = 0;
    b = hist_min;
    while (k + 1 < n) begin
      b = grow(b);
      if (b > d) break;
      k++;
    end
    case (c.orient)
      ORIENT_IN: if (tally_in[k] != CNT_SAT) tally_in[k] = tally_in[k] + 1'b1;
      ORIENT_OUT: if (tally_out[k] != CNT_SAT) tally_out[k] = tally_out[k] + 1'b1;
      ORIENT_SAME: if (tally_same[k] != CNT_SAT) tally_same[k] = tally_same[k] + 1'b1;
      default: ;
    endcase
    r = report_of(k);
    r.acc = (c.orient != ORIENT_OTHER);
    return r;
  endfunction

  function automatic pair_cmd_t random_pair();
    pair_cmd_t c;
    int unsigned k;
    int unsigned pick;
    c.cmd = CMD_RECORD;
    c.same = 1'b1;
    c.orient = orient_e'($urandom_range(3));
    c.rbin = BIN_W'($urandom);
    c.span = $urandom;
    pick = $urandom_range(99);
    if (pick < 12) begin
      c.cmd = CMD_READ;
    end else if (pick < 20) begin
      c.cmd = cmd_e'($urandom_range(1));
      c.same = 1'($urandom_range(1));
    end else if (pick < 28) begin
      if ($urandom_range(1) == 0) c.same = 1'b0;
      else if (hist_min != 0) c.span = $urandom_range(hist_min - 1, 0);
    end else begin
      k = $urandom_range(bins_used() - 1);
      case ($urandom_range(3))
        0: c.span = lower_bound(int'(k)) + $urandom_range(2) - 1;
        1: c.span = $urandom_range(hist_max, hist_min);
        2: c.span = hist_max + $urandom_range(2) - 1;
        default: ;
      endcase
    end
    return c;
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_MIN_DIST: hist_min = val;
      CFG_MAX_DIST: hist_max = val;
      CFG_RATIO: hist_ratio = val[RATIO_W-1:0];
      default: hist_nbins = val[BCNT_W-1:0];
    endcase
    @(posedge clk_i);
  endtask

  // Valid stays high after a transfer; the next call either idles or presents a new pair.
  task automatic send_pair(input pair_cmd_t c, input logic typed, input bin_report_t fixed);
    bin_report_t r;
    while ($urandom_range(99) < tx_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= c.cmd;
    same_chrom_i <= c.same;
    distance_i <= c.span;
    orientation_i <= c.orient;
    read_bin_i <= c.rbin;
    do @(posedge clk_i); while (in_stall_o);
    r = bin_and_count(c);
    bin_reports_due.insert(bin_reports_due.size(), typed ? fixed : r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (bin_reports_due.size() != 0);
  endtask

  task automatic check_report();
    bin_report_t want;
    bin_report_t got;
    got = '{bin_o, accepted_o, bin_lower_o, count_in_o, count_out_o, count_same_o};
    if (bin_reports_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected transfer: bin %0d lower %0d", got.bin, got.lower);
      return;
    end
    want = bin_reports_due.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch (exp/act): bin %0d/%0d acc %0d/%0d lower %0d/%0d in %0d/%0d %s",
                 want.bin, got.bin, want.acc, got.acc, want.lower, got.lower,
                 want.c_in, got.c_in,
                 $sformatf("out %0d/%0d same %0d/%0d", want.c_out, got.c_out,
                           want.c_same, got.c_same));
    end
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) check_report();
    out_stall_i <= ($urandom_range(99) < rx_pct);
  end

  initial begin
    phase_t ph;
    hist_min = MIN_DIST_RST;
    hist_max = MAX_DIST_RST;
    hist_ratio = RATIO_RST;
    hist_nbins = BCNT_RST;
    for (int i = 0; i < NBINS; i++) begin
      tally_in[i] = '0;
      tally_out[i] = '0;
      tally_same[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // hold until the counter sweep is over
    while (in_stall_o) @(posedge clk_i);
    for (int p = 0; p < 8; p++) begin
      ph = PHASES[p];
      if (ph.rnd) begin
        ph.min_d = $urandom_range(20000, 1);
        ph.max_d = $urandom_range(1) ? ph.min_d + $urandom_range(2000000) : $urandom;
        ph.ratio = RATIO_W'($urandom_range(65535, 257));
        ph.nbins = BCNT_W'($urandom_range(64, 1));
      end
      write_reg(CFG_MIN_DIST, ph.min_d);
      write_reg(CFG_MAX_DIST, ph.max_d);
      write_reg(CFG_RATIO, CFG_W'(ph.ratio));
      write_reg(CFG_BIN_COUNT, CFG_W'(ph.nbins));
      cfg_we_i <= 1'b0;
      tx_pct = ph.tx_pct;
      rx_pct = ph.rx_pct;
      if (p == 0)
        foreach (DIR_ROWS[i]) send_pair(DIR_ROWS[i].req, DIR_ROWS[i].typed, DIR_ROWS[i].rep);
      for (int i = 0; i < int'(ph.n_items); i++) begin
        send_pair(random_pair(), 1'b0, ZERO_REP);
        if (p == 0 && i == 100) drain();
      end
      drain();
    end
    repeat (80) @(posedge clk_i);
    if (mismatches == 0 && bin_reports_due.size() == 0)
      $display("** log_binned_distance_histogram: PASSED **");
    else
      $display("** log_binned_distance_histogram: FAILED **");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("** log_binned_distance_histogram: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
sv/lbdh_pkg.sv
sv/lbdh_walk.sv
sv/lbdh_store.sv
sv/log_binned_distance_histogram.sv
sv/lbdh_chk.sv
sim/tb.sv
